// ===== src/dvs_pkg.sv =====
`timescale 1ns / 1ps
package dvs_pkg;

    typedef struct packed {
        logic        [15:0] record_id;
        logic signed [31:0] axial_coef;
        logic signed [31:0] equatorial_cos_coef;
        logic signed [31:0] equatorial_sin_coef;
        logic               last_in;
    } dvs_in_t;

    typedef struct packed {
        logic        [15:0] record_out;
        logic        [31:0] magnitude;
        logic signed [23:0] tilt_angle;
        logic signed [23:0] longitude_angle;
        logic        [1:0]  status;
        logic               last_out;
    } dvs_out_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_LON_UNDEF  = 2'd1;
    localparam logic [1:0] ST_BOTH_UNDEF = 2'd2;

    // one root bit per step, 64-bit radicand
    localparam int ISQ_STEPS = 32;

    localparam logic signed [23:0] DEG90_Q16 = 24'sd5898240;
    localparam logic signed [31:0] DEG90_Q24 = 32'sd1509949440;

    // atan(2^-i) in degrees * 2^24, rounded to nearest
    function automatic logic signed [31:0] atan_entry(input int idx);
        logic signed [31:0] val;
        case (idx)
            0:       val = 32'sd754974720;
            1:       val = 32'sd445687602;
            2:       val = 32'sd235489088;
            3:       val = 32'sd119537938;
            4:       val = 32'sd60000934;
            5:       val = 32'sd30029717;
            6:       val = 32'sd15018523;
            7:       val = 32'sd7510720;
            8:       val = 32'sd3754917;
            9:       val = 32'sd1877466;
            10:      val = 32'sd938734;
            11:      val = 32'sd469367;
            12:      val = 32'sd234684;
            13:      val = 32'sd117342;
            14:      val = 32'sd58671;
            15:      val = 32'sd29335;
            16:      val = 32'sd14668;
            17:      val = 32'sd7334;
            18:      val = 32'sd3667;
            19:      val = 32'sd1833;
            20:      val = 32'sd917;
            21:      val = 32'sd458;
            22:      val = 32'sd229;
            23:      val = 32'sd115;
            24:      val = 32'sd57;
            25:      val = 32'sd29;
            26:      val = 32'sd14;
            27:      val = 32'sd7;
            28:      val = 32'sd4;
            29:      val = 32'sd2;
            30:      val = 32'sd1;
            default: val = 32'sd0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/dvs_isqrt.sv =====
`timescale 1ns / 1ps
module dvs_isqrt (
    input  logic        aclk,
    input  logic        ce,
    input  logic [63:0] radicand,
    output logic [31:0] root
);
    import dvs_pkg::*;

    typedef struct packed {
        logic [63:0] rest;
        logic [35:0] rem;
        logic [31:0] root;
    } isq_stage_t;

    isq_stage_t stage_reg  [ISQ_STEPS];
    isq_stage_t stage_next [ISQ_STEPS];

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
        isq_stage_t prev;
        logic [35:0] rem_sh;
        logic [35:0] trial;

        if (k == 0) begin : g_first
            assign prev = '{rest: radicand, rem: 36'd0, root: 32'd0};
        end else begin : g_rest
            assign prev = stage_reg[k-1];
        end

        always_comb begin
            rem_sh = {prev.rem[33:0], prev.rest[63:62]};
            trial  = {2'b00, prev.root, 2'b01};
            stage_next[k].rest = {prev.rest[61:0], 2'b00};
            if (rem_sh >= trial) begin
                stage_next[k].rem  = rem_sh - trial;
                stage_next[k].root = {prev.root[30:0], 1'b1};
            end else begin
                stage_next[k].rem  = rem_sh;
                stage_next[k].root = {prev.root[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign root = stage_reg[ISQ_STEPS-1].root;

endmodule

// ===== src/dvs_cordic.sv =====
`timescale 1ns / 1ps
module dvs_cordic #(
    parameter int STAGES = 24
) (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [32:0] num,
    input  logic signed [32:0] den,
    output logic signed [23:0] angle
);
    import dvs_pkg::*;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [31:0] z;
        logic               special;
        logic signed [23:0] sval;
    } cor_t;

    cor_t pre_reg;
    cor_t pre_next;
    cor_t it_reg  [STAGES];
    cor_t it_next [STAGES];

    logic signed [31:0] z_clamp;
    logic signed [32:0] z_round;
    logic signed [24:0] r_clamp;
    logic signed [23:0] angle_next;
    logic signed [23:0] angle_reg;

    // vertical and zero angles bypass the rotation
    always_comb begin
        pre_next.z       = 32'sd0;
        pre_next.special = (den == 33'sd0) || (num == 33'sd0);
        if (den == 33'sd0) begin
            pre_next.sval = (num > 33'sd0) ? DEG90_Q16 : -DEG90_Q16;
        end else begin
            pre_next.sval = 24'sd0;
        end
        if (den < 33'sd0) begin
            pre_next.x = -36'(den);
            pre_next.y = -36'(num);
        end else begin
            pre_next.x = 36'(den);
            pre_next.y = 36'(num);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pre_reg <= pre_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        cor_t prev;
        logic signed [35:0] dx;
        logic signed [35:0] dy;

        if (i == 0) begin : g_first
            assign prev = pre_reg;
        end else begin : g_rest
            assign prev = it_reg[i-1];
        end

        always_comb begin
            dx = prev.y >>> i;
            dy = prev.x >>> i;
            it_next[i] = prev;
            if (!prev.y[35]) begin
                it_next[i].x = prev.x + dx;
                it_next[i].y = prev.y - dy;
                it_next[i].z = prev.z + atan_entry(i);
            end else begin
                it_next[i].x = prev.x - dx;
                it_next[i].y = prev.y + dy;
                it_next[i].z = prev.z - atan_entry(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                it_reg[i] <= it_next[i];
            end
        end
    end

    // clamp, round to 1/65536 degree, clamp again
    always_comb begin
        z_clamp = it_reg[STAGES-1].z;
        if (z_clamp > DEG90_Q24) begin
            z_clamp = DEG90_Q24;
        end
        if (z_clamp < -DEG90_Q24) begin
            z_clamp = -DEG90_Q24;
        end
        z_round = (33'(z_clamp) + 33'sd128) >>> 8;
        r_clamp = 25'(z_round);
        if (r_clamp > 25'(DEG90_Q16)) begin
            r_clamp = 25'(DEG90_Q16);
        end
        if (r_clamp < -25'(DEG90_Q16)) begin
            r_clamp = -25'(DEG90_Q16);
        end
        angle_next = it_reg[STAGES-1].special ? it_reg[STAGES-1].sval : 24'(r_clamp);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// ===== src/dipole_vector_to_spherical_core.sv =====
`timescale 1ns / 1ps
// Channel  | Ports                       | Direction | Payload
// input    | s_valid, s_ready, s_data    | in        | dvs_pkg::dvs_in_t
// result   | m_valid, m_ready, m_data    | out       | dvs_pkg::dvs_out_t
//
// One transaction per cycle while the skid entry is free; the path runs through
// 5 front stages (abs, squares, normalize, squares, sum), 32 root steps
// (one root bit per stage), then CORDIC_STAGES + 2 rotation stages.
// aresetn (synchronous, active low) clears only valid bits and the skid.
// A stalled result sits in the output register; one more goes to a skid
// entry, and only while that entry is full does the pipeline freeze.
module dipole_vector_to_spherical_core #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dvs_pkg::dvs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dvs_pkg::dvs_out_t m_data
);
    import dvs_pkg::*;

    localparam int FRONT_LAT  = 5;
    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    localparam int LAT        = FRONT_LAT + ISQ_STEPS + CORDIC_LAT;

    // fields that ride alongside the root units
    typedef struct packed {
        logic        [15:0] id;
        logic               last;
        logic        [1:0]  status;
        logic signed [32:0] den_t;
        logic signed [32:0] lon_num;
        logic signed [32:0] lon_den;
    } side_t;

    typedef struct packed {
        logic [15:0] id;
        logic        last;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] uc;
        logic        an;
        logic        bn;
        logic        cn;
    } s1_t;

    typedef struct packed {
        logic [15:0] id;
        logic        last;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] uc;
        logic        an;
        logic        bn;
        logic        cn;
        logic [63:0] sqa;
        logic [63:0] sqb;
        logic [63:0] sqc;
        logic [4:0]  sh_t;
        logic [4:0]  sh_l;
    } s2_t;

    typedef struct packed {
        side_t       side;
        logic [63:0] mag_sum;
        logic [31:0] tb;
        logic [31:0] tc;
    } s3_t;

    typedef struct packed {
        side_t       side;
        logic [63:0] mag_sum;
        logic [63:0] tsqb;
        logic [63:0] tsqc;
    } s4_t;

    typedef struct packed {
        side_t       side;
        logic [63:0] mag_sum;
        logic [63:0] tilt_sum;
    } s5_t;

    typedef struct packed {
        logic [15:0] id;
        logic        last;
        logic [1:0]  status;
        logic [31:0] mag;
    } back_t;

    // shift that brings the largest operand to at least 2^30
    function automatic logic [4:0] norm_amt(input logic [31:0] m);
        logic [5:0] k;
        k = 6'd32;
        for (int j = 0; j < 32; j++) begin
            if (m[j]) begin
                k = 6'(31 - j);
            end
        end
        return (k == 6'd0) ? 5'd0 : 5'(k - 6'd1);
    endfunction

    logic ce;
    logic vld_reg [LAT];

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;

    logic [31:0] m_lon;
    logic [31:0] m_tilt;
    logic [31:0] ta;
    logic [31:0] lb;
    logic [31:0] lc;

    side_t side_a_reg [ISQ_STEPS];
    back_t side_b_reg [CORDIC_LAT];

    logic [31:0]        mag_root;
    logic [31:0]        tilt_root;
    logic signed [23:0] tilt_ang;
    logic signed [23:0] lon_ang;

    dvs_out_t res_next;
    logic     p_valid;
    dvs_out_t out_reg;
    dvs_out_t skid_reg;
    logic     out_valid_reg;
    logic     skid_valid_reg;

    // the whole pipeline moves unless the skid entry is taken
    assign ce      = !skid_valid_reg;
    assign s_ready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // stage 1: magnitudes and signs
    always_comb begin
        s1_next.id   = s_data.record_id;
        s1_next.last = s_data.last_in;
        s1_next.an   = s_data.axial_coef[31];
        s1_next.bn   = s_data.equatorial_cos_coef[31];
        s1_next.cn   = s_data.equatorial_sin_coef[31];
        s1_next.ua   = s_data.axial_coef[31] ? $unsigned(-s_data.axial_coef)
                                             : $unsigned(s_data.axial_coef);
        s1_next.ub   = s_data.equatorial_cos_coef[31] ?
                       $unsigned(-s_data.equatorial_cos_coef) :
                       $unsigned(s_data.equatorial_cos_coef);
        s1_next.uc   = s_data.equatorial_sin_coef[31] ?
                       $unsigned(-s_data.equatorial_sin_coef) :
                       $unsigned(s_data.equatorial_sin_coef);
    end

    // stage 2: squares for the length, normalize shifts
    always_comb begin
        m_lon  = (s1_reg.ub > s1_reg.uc) ? s1_reg.ub : s1_reg.uc;
        m_tilt = (s1_reg.ua > m_lon) ? s1_reg.ua : m_lon;
        s2_next.id   = s1_reg.id;
        s2_next.last = s1_reg.last;
        s2_next.ua   = s1_reg.ua;
        s2_next.ub   = s1_reg.ub;
        s2_next.uc   = s1_reg.uc;
        s2_next.an   = s1_reg.an;
        s2_next.bn   = s1_reg.bn;
        s2_next.cn   = s1_reg.cn;
        s2_next.sqa  = {32'd0, s1_reg.ua} * {32'd0, s1_reg.ua};
        s2_next.sqb  = {32'd0, s1_reg.ub} * {32'd0, s1_reg.ub};
        s2_next.sqc  = {32'd0, s1_reg.uc} * {32'd0, s1_reg.uc};
        s2_next.sh_t = norm_amt(m_tilt);
        s2_next.sh_l = norm_amt(m_lon);
    end

    // stage 3: length sum, scaled operands, status
    always_comb begin
        ta = s2_reg.ua << s2_reg.sh_t;
        lb = s2_reg.ub << s2_reg.sh_l;
        lc = s2_reg.uc << s2_reg.sh_l;
        s3_next.mag_sum     = s2_reg.sqa + s2_reg.sqb + s2_reg.sqc;
        s3_next.tb          = s2_reg.ub << s2_reg.sh_t;
        s3_next.tc          = s2_reg.uc << s2_reg.sh_t;
        s3_next.side.id     = s2_reg.id;
        s3_next.side.last   = s2_reg.last;
        s3_next.side.den_t   = s2_reg.an ? -$signed({1'b0, ta}) : $signed({1'b0, ta});
        s3_next.side.lon_num = s2_reg.cn ? -$signed({1'b0, lc}) : $signed({1'b0, lc});
        s3_next.side.lon_den = s2_reg.bn ? -$signed({1'b0, lb}) : $signed({1'b0, lb});
        if (s2_reg.ub == 32'd0 && s2_reg.uc == 32'd0) begin
            s3_next.side.status = (s2_reg.ua == 32'd0) ? ST_BOTH_UNDEF : ST_LON_UNDEF;
        end else begin
            s3_next.side.status = ST_OK;
        end
    end

    // stage 4: equatorial squares of the scaled operands
    always_comb begin
        s4_next.side    = s3_reg.side;
        s4_next.mag_sum = s3_reg.mag_sum;
        s4_next.tsqb    = {32'd0, s3_reg.tb} * {32'd0, s3_reg.tb};
        s4_next.tsqc    = {32'd0, s3_reg.tc} * {32'd0, s3_reg.tc};
    end

    // stage 5: equatorial sum
    always_comb begin
        s5_next.side     = s4_reg.side;
        s5_next.mag_sum  = s4_reg.mag_sum;
        s5_next.tilt_sum = s4_reg.tsqb + s4_reg.tsqc;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    dvs_isqrt u_mag_root (
        .aclk     (aclk),
        .ce       (ce),
        .radicand (s5_reg.mag_sum),
        .root     (mag_root)
    );

    dvs_isqrt u_tilt_root (
        .aclk     (aclk),
        .ce       (ce),
        .radicand (s5_reg.tilt_sum),
        .root     (tilt_root)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            side_a_reg[0] <= s5_reg.side;
            for (int k = 1; k < ISQ_STEPS; k++) begin
                side_a_reg[k] <= side_a_reg[k-1];
            end
        end
    end

    dvs_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_tilt_cordic (
        .aclk  (aclk),
        .ce    (ce),
        .num   ($signed({1'b0, tilt_root})),
        .den   (side_a_reg[ISQ_STEPS-1].den_t),
        .angle (tilt_ang)
    );

    dvs_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_lon_cordic (
        .aclk  (aclk),
        .ce    (ce),
        .num   (side_a_reg[ISQ_STEPS-1].lon_num),
        .den   (side_a_reg[ISQ_STEPS-1].lon_den),
        .angle (lon_ang)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            side_b_reg[0] <= '{id:     side_a_reg[ISQ_STEPS-1].id,
                               last:   side_a_reg[ISQ_STEPS-1].last,
                               status: side_a_reg[ISQ_STEPS-1].status,
                               mag:    mag_root};
            for (int k = 1; k < CORDIC_LAT; k++) begin
                side_b_reg[k] <= side_b_reg[k-1];
            end
        end
    end

    // undefined angles are forced to zero
    always_comb begin
        res_next.record_out      = side_b_reg[CORDIC_LAT-1].id;
        res_next.magnitude       = side_b_reg[CORDIC_LAT-1].mag;
        res_next.status          = side_b_reg[CORDIC_LAT-1].status;
        res_next.last_out        = side_b_reg[CORDIC_LAT-1].last;
        res_next.tilt_angle      = (side_b_reg[CORDIC_LAT-1].status == ST_BOTH_UNDEF) ?
                                   24'sd0 : tilt_ang;
        res_next.longitude_angle = (side_b_reg[CORDIC_LAT-1].status != ST_OK) ?
                                   24'sd0 : lon_ang;
    end

    assign p_valid = vld_reg[LAT-1];

    // output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_ready || !out_valid_reg) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= p_valid;
                end
            end else if (!skid_valid_reg && p_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : res_next;
        end else if (!skid_valid_reg) begin
            skid_reg <= res_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_both_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_BOTH_UNDEF) |->
        (m_data.tilt_angle == 24'sd0 && m_data.longitude_angle == 24'sd0))
        else $error("angles nonzero with both undefined");

    a_lon_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_LON_UNDEF) |-> (m_data.longitude_angle == 24'sd0))
        else $error("longitude nonzero while undefined");

    a_tilt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.tilt_angle <= DEG90_Q16 && m_data.tilt_angle >= -DEG90_Q16))
        else $error("tilt angle beyond 90 degrees");
`endif

endmodule
